FILE: sv/tpool_pkg.sv
// tpool_pkg: shared types and constants for the one-shot timer pool
// no dependencies; compiled before every other file of the block
package tpool_pkg;

    localparam int PERIOD_W    = 32;
    localparam int SLOT_W      = 8;
    localparam int PERIOD_STEP = 10;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_STATUS = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_EXPIRY = 2'd0,
        KIND_START  = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    // access to the remaining-count memory
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [SLOT_W-1:0]   addr;
        logic [PERIOD_W-1:0] wr_data;
    } mem_req_t;

    // status of the serial remainder checker
    typedef struct packed {
        logic done;
        logic ok;
    } mod_stat_t;

endpackage

FILE: sv/tpool_req_if.sv
// tpool_req_if: request channel of the timer pool (opcode, period, slot id)
// depends on tpool_pkg for field widths
interface tpool_req_if;
    import tpool_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [PERIOD_W-1:0] period;
    logic [SLOT_W-1:0]   slot_id;

    modport source (output valid, output opcode, output period, output slot_id, input ready);
    modport sink   (input valid, input opcode, input period, input slot_id, output ready);
endinterface

FILE: sv/tpool_rsp_if.sv
// tpool_rsp_if: result channel of the timer pool (kind, slot, ok, running, last)
// depends on tpool_pkg for field widths
interface tpool_rsp_if;
    import tpool_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic              running;
    logic              last;

    modport source (output valid, output kind, output slot, output ok, output running,
                    output last, input ready);
    modport sink   (input valid, input kind, input slot, input ok, input running,
                    input last, output ready);
endinterface

FILE: sv/tpool_mod10.sv
// tpool_mod10: remainder-by-ten check of a start period
// nibble sum registered on start, then fold and compare-subtract on the registered sum
// depends on tpool_pkg
module tpool_mod10 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpool_pkg::PERIOD_W-1:0] value,
    output tpool_pkg::mod_stat_t          stat
);
    import tpool_pkg::*;

    localparam int NIBBLES   = PERIOD_W / 4;
    localparam int SUM_W     = $clog2(NIBBLES * 15 + 1);
    localparam int HALF_STEP = PERIOD_STEP / 2;

    logic             busy_reg, busy_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             even_reg, even_next;
    logic             nz_reg, nz_next;
    logic             ok_reg, ok_next;
    logic [SUM_W-1:0] nib_sum;
    logic [4:0]       fold;
    logic [4:0]       rem_a;
    logic [4:0]       rem_b;
    logic [4:0]       rem_c;

    // 16 is 1 mod 5, so the value and its nibble sum agree mod 5
    always_comb
    begin
        nib_sum = '0;
        for (int i = 0; i < NIBBLES; i++)
            nib_sum = nib_sum + SUM_W'(value[4*i +: 4]);
    end

    // same trick once more on the 7-bit sum, at most 7 + 15
    assign fold  = 5'(sum_reg[SUM_W-1:4]) + 5'(sum_reg[3:0]);
    assign rem_a = (fold >= 5'(3 * HALF_STEP)) ? fold - 5'(3 * HALF_STEP) : fold;
    assign rem_b = (rem_a >= 5'(HALF_STEP)) ? rem_a - 5'(HALF_STEP) : rem_a;
    assign rem_c = (rem_b >= 5'(HALF_STEP)) ? rem_b - 5'(HALF_STEP) : rem_b;

    always_comb
    begin
        busy_next = busy_reg;
        sum_next  = sum_reg;
        even_next = even_reg;
        nz_next   = nz_reg;
        ok_next   = ok_reg;
        if (start)
        begin
            busy_next = 1'b1;
            sum_next  = nib_sum;
            even_next = !value[0];
            nz_next   = |value;
            ok_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            // multiple of ten: even, nonzero and a multiple of five
            ok_next   = even_reg && nz_reg && (rem_c == '0);
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sum_reg  <= '0;
            even_reg <= 1'b0;
            nz_reg   <= 1'b0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            sum_reg  <= sum_next;
            even_reg <= even_next;
            nz_reg   <= nz_next;
            ok_reg   <= ok_next;
        end
    end

    assign stat.done = !busy_reg;
    assign stat.ok   = ok_reg;

endmodule

FILE: sv/tpool_rem_mem.sv
// tpool_rem_mem: remaining-tick store, one write and one registered read port
// depends on tpool_pkg for the access struct
module tpool_rem_mem #(
    parameter int SLOTS = 8
) (
    input  logic                           clk,
    input  tpool_pkg::mem_req_t            req,
    output logic [tpool_pkg::PERIOD_W-1:0] rd_data
);
    import tpool_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [PERIOD_W-1:0] mem [SLOTS];
    logic [PERIOD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.addr[IDX_W-1:0]] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.addr[IDX_W-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/one_shot_timer_pool.sv
// one_shot_timer_pool: top level, sequencer and slot state of the timer pool
// depends on tpool_pkg, tpool_req_if, tpool_rsp_if, tpool_mod10, tpool_rem_mem
//
// usage
//   req channel: one beat per operation (tick, start, stop, status); ready is
//   high only while the sequencer is idle, one operation is in flight at a time
//   rsp channel: start, stop and status give one beat each with last set; a
//   tick gives one expiry beat per slot that reached zero, in ascending slot
//   order, last set on the final one, and no beat when nothing expires
// sequencing, from the accepted request to the loaded result
//   stop and status: straight to the reply; start: the free-slot scan of one
//   slot per cycle, with the remainder-by-ten check running alongside
//   tick: idle slots are stepped past, each running slot takes a memory read,
//   then decrement and write back through the single port pair, and a closing step
//   reset: all slots idle; the remaining-count memory needs no clearing pass
//   since a slot's count is always written by its start before it is read
//   stall: results sit in one output register; a tick sweep pauses while a
//   held expiry cannot be handed on, and a new request is accepted as soon as
//   the previous result is loaded, even if the receiver has not taken it yet
module one_shot_timer_pool #(
    parameter int SLOTS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    tpool_req_if.sink   req,
    tpool_rsp_if.source rsp
);
    import tpool_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = (IDX_W > 1) ? IDX_W : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_WB,
        S_TICK_END,
        S_START,
        S_REPLY
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;       // slot pointer for sweeps and scan
    opcode_t             op_reg, op_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [SLOT_W-1:0]   id_reg, id_next;
    logic                scan_done_reg, scan_done_next;
    logic                found_reg, found_next;
    logic [SLOTS-1:0]    running_reg, running_next;
    logic                pend_valid_reg, pend_valid_next;  // expiry held back for last marker
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_ok_reg, out_ok_next;
    logic                out_run_reg, out_run_next;
    logic                out_last_reg, out_last_next;

    mem_req_t            mem_req;
    logic [PERIOD_W-1:0] mem_rd;
    logic                mod_start;
    mod_stat_t           mod_stat;

    logic                out_free;
    logic                last_idx;
    logic                cur_run;
    logic [PERIOD_W-1:0] dec;
    logic                expire;
    logic                id_ok;
    logic                id_run;
    logic                start_ok;

    tpool_mod10 u_mod10 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (req.period),
        .stat  (mod_stat)
    );

    tpool_rem_mem #(
        .SLOTS (SLOTS)
    ) u_rem_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    // shared compare / decrement datapath
    assign out_free = !out_valid_reg || rsp.ready;
    assign last_idx = (cnt_reg == CNT_W'(SLOTS - 1));
    assign cur_run  = running_reg[cnt_reg[IDX_W-1:0]];
    assign dec      = mem_rd - 1'b1;
    assign expire   = (dec == '0);
    assign id_ok    = (id_reg < SLOT_W'(SLOTS));
    assign id_run   = id_ok && running_reg[id_reg[IDX_W-1:0]];
    assign start_ok = found_reg && mod_stat.ok;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        period_next     = period_reg;
        id_next         = id_reg;
        scan_done_next  = scan_done_reg;
        found_next      = found_reg;
        running_next    = running_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_ok_next     = out_ok_reg;
        out_run_next    = out_run_reg;
        out_last_next   = out_last_reg;
        mem_req         = '0;
        mod_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = opcode_t'(req.opcode);
                    period_next = req.period;
                    id_next     = req.slot_id;
                    cnt_next    = '0;
                    case (opcode_t'(req.opcode))
                        OP_TICK:
                        begin
                            state_next = S_TICK_RD;
                        end
                        OP_START:
                        begin
                            mod_start      = 1'b1;
                            scan_done_next = 1'b0;
                            found_next     = 1'b0;
                            state_next     = S_START;
                        end
                        default:
                        begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end

            S_TICK_RD:
            begin
                if (cur_run)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = SLOT_W'(cnt_reg);
                    state_next    = S_TICK_WB;
                end
                else if (last_idx)
                    state_next = S_TICK_END;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            S_TICK_WB:
            begin
                // hold the whole step if a new expiry would push out a held one
                // while the output register is still full
                if (!(expire && pend_valid_reg && !out_free))
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.addr    = SLOT_W'(cnt_reg);
                    mem_req.wr_data = dec;
                    if (expire)
                    begin
                        running_next[cnt_reg[IDX_W-1:0]] = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = SLOT_W'(cnt_reg);
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_EXPIRY;
                            out_slot_next  = pend_slot_reg;
                            out_ok_next    = 1'b1;
                            out_run_next   = 1'b0;
                            out_last_next  = 1'b0;
                        end
                    end
                    if (last_idx)
                        state_next = S_TICK_END;
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_TICK_RD;
                    end
                end
            end

            S_TICK_END:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_EXPIRY;
                    out_slot_next   = pend_slot_reg;
                    out_ok_next     = 1'b1;
                    out_run_next    = 1'b0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_START:
            begin
                // lowest idle slot search; cnt stops on the hit
                if (!scan_done_reg)
                begin
                    if (!cur_run)
                    begin
                        found_next     = 1'b1;
                        scan_done_next = 1'b1;
                    end
                    else if (last_idx)
                        scan_done_next = 1'b1;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
                else if (mod_stat.done)
                    state_next = S_REPLY;
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_run_next   = 1'b0;
                    state_next     = S_IDLE;
                    case (op_reg)
                        OP_START:
                        begin
                            out_kind_next = KIND_START;
                            out_ok_next   = start_ok;
                            out_slot_next = start_ok ? SLOT_W'(cnt_reg) : '0;
                            if (start_ok)
                            begin
                                running_next[cnt_reg[IDX_W-1:0]] = 1'b1;
                                mem_req.wr_en   = 1'b1;
                                mem_req.addr    = SLOT_W'(cnt_reg);
                                mem_req.wr_data = period_reg;
                            end
                        end
                        OP_STOP:
                        begin
                            out_kind_next = KIND_STOP;
                            out_ok_next   = id_ok;
                            out_slot_next = id_ok ? id_reg : '0;
                            out_run_next  = id_run;
                            if (id_run)
                            begin
                                running_next[id_reg[IDX_W-1:0]] = 1'b0;
                                mem_req.wr_en   = 1'b1;
                                mem_req.addr    = id_reg;
                                mem_req.wr_data = '0;
                            end
                        end
                        OP_STATUS:
                        begin
                            out_kind_next = KIND_STATUS;
                            out_ok_next   = id_ok;
                            out_slot_next = id_ok ? id_reg : '0;
                            out_run_next  = id_run;
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            op_reg         <= OP_TICK;
            scan_done_reg  <= 1'b0;
            found_reg      <= 1'b0;
            running_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            op_reg         <= op_next;
            scan_done_reg  <= scan_done_next;
            found_reg      <= found_next;
            running_reg    <= running_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        period_reg    <= period_next;
        id_reg        <= id_next;
        pend_slot_reg <= pend_slot_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_ok_reg    <= out_ok_next;
        out_run_reg   <= out_run_next;
        out_last_reg  <= out_last_next;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.kind    = out_kind_reg;
    assign rsp.slot    = out_slot_reg;
    assign rsp.ok      = out_ok_reg;
    assign rsp.running = out_run_reg;
    assign rsp.last    = out_last_reg;

    // one operation in flight: an accepted beat always leaves idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while an operation was still in flight");

    // only a tick sweep produces beats without the last marker
    a_multi_only_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |-> rsp.kind == KIND_EXPIRY)
        else $error("non-expiry result without last marker");

    // a refused start reports slot zero
    a_refused_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind == KIND_START && !rsp.ok |-> rsp.slot == '0)
        else $error("refused start carries a nonzero slot");

    // a held expiry exists only while a tick sweep is running
    a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_TICK_RD || state_reg == S_TICK_WB ||
                            state_reg == S_TICK_END))
        else $error("held expiry outside a tick sweep");

    // expiry beats are always ok and never flag running
    a_expiry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind == KIND_EXPIRY |-> rsp.ok && !rsp.running)
        else $error("malformed expiry result");

endmodule
